[src/adip_pkg.sv]
// Package for the ASCII decimal integer parser.
// Holds the item structs for both channels and the character constants.
// No dependencies.
`default_nettype none

package adip_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] IGN_NONE = 8'h00;

	localparam logic [63:0] MAG_LIMIT_DIV10 = 64'd922337203685477580;
	localparam logic [3:0]  MAG_LIMIT_LAST  = 4'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic               found;
		logic               overflow;
	} out_item_t;

endpackage

`default_nettype wire

[src/ascii_decimal_int_parser.sv]
// ASCII decimal integer parser: top level, one byte per item in, one number per item out.
// Depends on adip_pkg for the item structs and character constants.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_stall  | in_item  (data_byte, end_of_data)
//   out     | output    | out_valid / out_stall| out_item (value, found, overflow)
//   cfg     | input     | cfg_wr_en            | cfg_wr_data (ignore_char)
//
// One byte is accepted per cycle while in_stall is low; the whole step (class, x10 add, limit compare)
// is one level of logic between the parse state registers and the result register.
// A number is registered when the byte that ends it is accepted and appears at out in the cycle after.
// in_stall is high only while a result waits in the output register and out is stalled.
// Reset clears the parse state, the ignore character and the output valid.
`default_nettype none

module ascii_decimal_int_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_wr_en,
	input  wire [7:0]            cfg_wr_data,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  adip_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  wire                  out_stall,
	output adip_pkg::out_item_t  out_item
);

	logic [7:0]  ignore_char_q;
	logic [63:0] magnitude_q;
	logic        negative_q;
	logic        at_first_q;
	logic        digit_seen_q;
	logic        in_progress_q;
	logic        overflowed_q;
	logic        out_valid_q;
	adip_pkg::out_item_t out_item_q;

	logic        accept;
	logic        emit;
	logic [63:0] magnitude_d;
	logic        negative_d;
	logic        at_first_d;
	logic        digit_seen_d;
	logic        in_progress_d;
	logic        overflowed_d;
	adip_pkg::out_item_t result;

	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		logic [7:0]  c;
		logic        is_sign;
		logic        is_dot;
		logic        is_ign;
		logic        is_digit;
		logic        taken;
		logic [3:0]  d;
		logic [63:0] src_mag;
		logic        src_neg;
		logic        src_first;
		logic        src_seen;
		logic        src_prog;
		logic        src_ovf;
		c        = in_item.data_byte;
		d        = c[3:0];
		is_sign  = (c == adip_pkg::CH_MINUS) || (c == adip_pkg::CH_PLUS);
		is_dot   = (c == adip_pkg::CH_DOT);
		is_ign   = (ignore_char_q != adip_pkg::IGN_NONE) && (c == ignore_char_q)
			&& !is_sign && !is_dot;
		is_digit = (c >= adip_pkg::CH_ZERO) && (c <= adip_pkg::CH_NINE) && !is_ign;
		taken    = ((is_sign | is_ign) & at_first_q) | is_digit;

		result.found    = digit_seen_q;
		result.overflow = overflowed_q;
		if (!digit_seen_q) begin
			result.value = '0;
		end else if (negative_q) begin
			result.value = -$signed(magnitude_q);
		end else begin
			result.value = $signed(magnitude_q);
		end

		// restart from a clear parse when the byte ends the current one
		if (taken) begin
			src_mag   = magnitude_q;
			src_neg   = negative_q;
			src_first = at_first_q;
			src_seen  = digit_seen_q;
			src_prog  = in_progress_q;
			src_ovf   = overflowed_q;
		end else begin
			src_mag   = '0;
			src_neg   = 1'b0;
			src_first = 1'b1;
			src_seen  = 1'b0;
			src_prog  = 1'b0;
			src_ovf   = 1'b0;
		end

		magnitude_d   = src_mag;
		negative_d    = src_neg;
		at_first_d    = src_first;
		digit_seen_d  = src_seen;
		in_progress_d = src_prog;
		overflowed_d  = src_ovf;

		if (is_sign && src_first) begin
			negative_d    = src_neg | (c == adip_pkg::CH_MINUS);
			at_first_d    = 1'b0;
			in_progress_d = 1'b1;
		end else if (is_ign && src_first) begin
			in_progress_d = 1'b1;
		end else if (is_digit) begin
			magnitude_d   = {src_mag[60:0], 3'b000} + {src_mag[62:0], 1'b0} + {60'd0, d};
			overflowed_d  = src_ovf || (src_mag > adip_pkg::MAG_LIMIT_DIV10)
				|| ((src_mag == adip_pkg::MAG_LIMIT_DIV10) && (d > adip_pkg::MAG_LIMIT_LAST));
			at_first_d    = 1'b0;
			digit_seen_d  = 1'b1;
			in_progress_d = 1'b1;
		end

		if (in_item.end_of_data) begin
			emit          = in_progress_q;
			magnitude_d   = '0;
			negative_d    = 1'b0;
			at_first_d    = 1'b1;
			digit_seen_d  = 1'b0;
			in_progress_d = 1'b0;
			overflowed_d  = 1'b0;
		end else begin
			emit = !taken && in_progress_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_char_q <= adip_pkg::IGN_NONE;
			magnitude_q   <= '0;
			negative_q    <= 1'b0;
			at_first_q    <= 1'b1;
			digit_seen_q  <= 1'b0;
			in_progress_q <= 1'b0;
			overflowed_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ignore_char_q <= cfg_wr_data;
			end
			if (accept) begin
				magnitude_q   <= magnitude_d;
				negative_q    <= negative_d;
				at_first_q    <= at_first_d;
				digit_seen_q  <= digit_seen_d;
				in_progress_q <= in_progress_d;
				overflowed_q  <= overflowed_d;
			end
			if (accept && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_item_q <= result;
		end
	end

	a_eod_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.end_of_data) |=> (!in_progress_q && at_first_q))
		else $error("end of data did not clear the parse");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_progress_q |-> (magnitude_q == '0 && !digit_seen_q && !negative_q
			&& !overflowed_q && at_first_q))
		else $error("idle parse state not clear");

	a_seen_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		digit_seen_q |-> (!at_first_q && in_progress_q))
		else $error("digit seen while still at first character");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_item_q.found) |-> (out_item_q.value == '0 && !out_item_q.overflow))
		else $error("item without digits carries a value");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty output register");

endmodule

`default_nettype wire
